// File: sv/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

  localparam int unsigned DivW = 64;
  localparam logic [15:0] PressScale = 16'd3125;
  localparam logic [31:0] HumLimit = 32'd419430400;
  localparam logic [16:0] HumMax = 17'd102400;

  typedef enum logic [2:0] {
    CfgTemp,
    CfgPressLow,
    CfgPressMid,
    CfgPressNine,
    CfgHumLow,
    CfgHumHigh
  } cfg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [23:0]        pressure_pascal;
    logic [16:0]        humidity_q10;
    logic               pressure_invalid;
  } out_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [15:0] h4;
    logic [15:0] h5;
    logic [7:0]  h6;
  } coeff_t;

  typedef struct packed {
    logic        neg;
    logic        invalid;
    logic [31:0] temp;
    logic [16:0] hum;
  } div_side_t;

  typedef struct packed {
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
    div_side_t       side;
  } div_in_t;

  typedef struct packed {
    logic [DivW-1:0] quo;
    div_side_t       side;
  } div_out_t;

  function automatic logic [31:0] sx16w32(input logic [15:0] c);
    return {{16{c[15]}}, c};
  endfunction

  function automatic logic [31:0] sx8w32(input logic [7:0] c);
    return {{24{c[7]}}, c};
  endfunction

  function automatic logic [63:0] sx16w64(input logic [15:0] c);
    return {{48{c[15]}}, c};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

  function automatic logic [63:0] mul32w(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic logic [63:0] mul64s16(input logic [63:0] x, input logic [15:0] c);
    logic signed [80:0] p;
    p = $signed({1'b0, x}) * $signed(c);
    return p[63:0];
  endfunction

  function automatic logic [63:0] mul64u16(input logic [63:0] x, input logic [15:0] c);
    logic [79:0] p;
    p = x * c;
    return p[63:0];
  endfunction

endpackage

// File: sv/esc_cfg.sv
`timescale 1ns / 1ps

module esc_cfg import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output coeff_t      coeff_o
);

  logic [47:0] temp_q;
  logic [63:0] plow_q;
  logic [63:0] pmid_q;
  logic [15:0] p9_q;
  logic [31:0] hlow_q;
  logic [39:0] hhigh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q  <= '0;
      plow_q  <= '0;
      pmid_q  <= '0;
      p9_q    <= '0;
      hlow_q  <= '0;
      hhigh_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTemp:      temp_q  <= cfg_data_i[47:0];
        CfgPressLow:  plow_q  <= cfg_data_i;
        CfgPressMid:  pmid_q  <= cfg_data_i;
        CfgPressNine: p9_q    <= cfg_data_i[15:0];
        CfgHumLow:    hlow_q  <= cfg_data_i[31:0];
        CfgHumHigh:   hhigh_q <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  assign coeff_o.t1 = temp_q[15:0];
  assign coeff_o.t2 = temp_q[31:16];
  assign coeff_o.t3 = temp_q[47:32];
  assign coeff_o.p1 = plow_q[15:0];
  assign coeff_o.p2 = plow_q[31:16];
  assign coeff_o.p3 = plow_q[47:32];
  assign coeff_o.p4 = plow_q[63:48];
  assign coeff_o.p5 = pmid_q[15:0];
  assign coeff_o.p6 = pmid_q[31:16];
  assign coeff_o.p7 = pmid_q[47:32];
  assign coeff_o.p8 = pmid_q[63:48];
  assign coeff_o.p9 = p9_q;
  assign coeff_o.h1 = hlow_q[7:0];
  assign coeff_o.h2 = hlow_q[23:8];
  assign coeff_o.h3 = hlow_q[31:24];
  assign coeff_o.h4 = hhigh_q[15:0];
  assign coeff_o.h5 = hhigh_q[31:16];
  assign coeff_o.h6 = hhigh_q[39:32];

endmodule

// File: sv/esc_front.sv
`timescale 1ns / 1ps

module esc_front import esc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    in_valid_i,
  input  in_t     in_data_i,
  input  coeff_t  coeff_i,
  output logic    out_valid_o,
  output div_in_t out_data_o
);

  logic [9:0] vld_q;

  // temperature stages
  logic [31:0] ta, tb;
  logic [31:0] t1_pa_d, t1_pa_q, t1_bb_d, t1_bb_q;
  logic [31:0] t2_v1_d, t2_v1_q, t2_m3_d, t2_m3_q;
  logic [31:0] fine_d, fine_q, temp_d, temp_q;
  logic [19:0] rawp_q [7];
  logic [15:0] rawh_q [4];
  logic [31:0] tpipe_q [6];

  // pressure stages
  logic [63:0] f1_q1;
  logic [63:0] f1_lo_d, f1_lo_q, f1_m5_d, f1_m5_q, f1_m2_d, f1_m2_q;
  logic [31:0] f1_cr_d, f1_cr_q;
  logic [63:0] f2_sq_d, f2_sq_q, f2_m5_q, f2_m2_q;
  logic [63:0] f3_a6_d, f3_a6_q, f3_a3_d, f3_a3_q, f3_m5_q, f3_m2_q;
  logic [63:0] p4e;
  logic [63:0] f4_q2_d, f4_q2_q, f4_s_d, f4_s_q;
  logic [63:0] pdiff;
  logic [63:0] f5_pr_d, f5_pr_q, f5_n0_d, f5_n0_q;
  logic [63:0] f6_dv_d, f6_dv_q, f6_n_d, f6_n_q;

  // humidity stages
  logic [31:0] f1_hv;
  logic [31:0] f1_h5_d, f1_h5_q, f1_h6_d, f1_h6_q, f1_h3_d, f1_h3_q;
  logic [31:0] h4e;
  logic [31:0] f2_x_d, f2_x_q, f2_mi_d, f2_mi_q;
  logic [31:0] f3_yp_d, f3_yp_q, f3_x_q;
  logic [31:0] f4_hv_d, f4_hv_q;
  logic [31:0] f5_w;
  logic [31:0] f5_ww_d, f5_ww_q, f5_hv_q;
  logic [31:0] f6_t_d, f6_t_q, f6_hv_q;
  logic [31:0] hr;
  logic [31:0] hc;

  div_in_t out_d, out_q;

  assign ta = {15'b0, in_data_i.raw_temperature[19:3]} - {15'b0, coeff_i.t1, 1'b0};
  assign tb = {16'b0, in_data_i.raw_temperature[19:4]} - {16'b0, coeff_i.t1};
  assign t1_pa_d = mul32(ta, sx16w32(coeff_i.t2));
  assign t1_bb_d = mul32(tb, tb);

  assign t2_v1_d = asr32(t1_pa_q, 11);
  assign t2_m3_d = mul32(asr32(t1_bb_q, 12), sx16w32(coeff_i.t3));

  assign fine_d = t2_v1_q + asr32(t2_m3_q, 14);
  assign temp_d = asr32((fine_d << 2) + fine_d + 32'd128, 8);

  assign f1_q1   = {{32{fine_q[31]}}, fine_q} - 64'd128000;
  assign f1_lo_d = mul32w(f1_q1[31:0], f1_q1[31:0]);
  assign f1_cr_d = mul32(f1_q1[31:0], f1_q1[63:32]);
  assign f1_m5_d = mul64s16(f1_q1, coeff_i.p5);
  assign f1_m2_d = mul64s16(f1_q1, coeff_i.p2);
  assign f1_hv   = fine_q - 32'd76800;
  assign f1_h5_d = mul32(sx16w32(coeff_i.h5), f1_hv);
  assign f1_h6_d = mul32(f1_hv, sx8w32(coeff_i.h6));
  assign f1_h3_d = mul32(f1_hv, {24'b0, coeff_i.h3});

  assign f2_sq_d = f1_lo_q + {f1_cr_q[30:0], 33'b0};
  assign h4e     = sx16w32(coeff_i.h4);
  assign f2_x_d  = asr32({2'b0, rawh_q[3], 14'b0} - {h4e[11:0], 20'b0} - f1_h5_q
                         + 32'd16384, 15);
  assign f2_mi_d = mul32(asr32(f1_h6_q, 10), asr32(f1_h3_q, 11) + 32'd32768);

  assign f3_a6_d = mul64s16(f2_sq_q, coeff_i.p6);
  assign f3_a3_d = mul64s16(f2_sq_q, coeff_i.p3);
  assign f3_yp_d = mul32(asr32(f2_mi_q, 10) + 32'd2097152, sx16w32(coeff_i.h2));

  assign p4e     = sx16w64(coeff_i.p4);
  assign f4_q2_d = f3_a6_q + {f3_m5_q[46:0], 17'b0} + {p4e[28:0], 35'b0};
  assign f4_s_d  = 64'h0000_8000_0000_0000 + asr64(f3_a3_q, 8) + {f3_m2_q[51:0], 12'b0};
  assign f4_hv_d = mul32(f3_x_q, asr32(f3_yp_q + 32'd8192, 14));

  assign pdiff   = 64'd1048576 - {44'b0, rawp_q[6]};
  assign f5_pr_d = mul64u16(f4_s_q, coeff_i.p1);
  assign f5_n0_d = {pdiff[32:0], 31'b0} - f4_q2_q;
  assign f5_w    = asr32(f4_hv_q, 15);
  assign f5_ww_d = mul32(f5_w, f5_w);

  assign f6_dv_d = asr64(f5_pr_q, 33);
  assign f6_n_d  = mul64u16(f5_n0_q, PressScale);
  assign f6_t_d  = mul32(asr32(f5_ww_q, 7), {24'b0, coeff_i.h1});

  assign hr = f6_hv_q - asr32(f6_t_q, 4);

  always_comb begin
    if (hr[31]) begin
      hc = '0;
    end else if (hr > HumLimit) begin
      hc = HumLimit;
    end else begin
      hc = hr;
    end
    out_d.num          = f6_n_q[63] ? 64'd0 - f6_n_q : f6_n_q;
    out_d.den          = f6_dv_q[63] ? 64'd0 - f6_dv_q : f6_dv_q;
    out_d.side.neg     = f6_n_q[63] ^ f6_dv_q[63];
    out_d.side.invalid = (f6_dv_q == '0);
    out_d.side.temp    = tpipe_q[5];
    out_d.side.hum     = hc[28:12];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[8:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_pa_q    <= t1_pa_d;
      t1_bb_q    <= t1_bb_d;
      t2_v1_q    <= t2_v1_d;
      t2_m3_q    <= t2_m3_d;
      fine_q     <= fine_d;
      temp_q     <= temp_d;
      tpipe_q[0] <= temp_q;
      for (int k = 1; k < 6; k++) begin
        tpipe_q[k] <= tpipe_q[k-1];
      end
      // raw values: T1, T2, T3, F1 for humidity and T1..F4 for pressure
      rawh_q[0] <= in_data_i.raw_humidity;
      rawp_q[0] <= in_data_i.raw_pressure;
      for (int k = 1; k < 4; k++) begin
        rawh_q[k] <= rawh_q[k-1];
      end
      for (int k = 1; k < 7; k++) begin
        rawp_q[k] <= rawp_q[k-1];
      end
      f1_lo_q <= f1_lo_d;
      f1_cr_q <= f1_cr_d;
      f1_m5_q <= f1_m5_d;
      f1_m2_q <= f1_m2_d;
      f1_h5_q <= f1_h5_d;
      f1_h6_q <= f1_h6_d;
      f1_h3_q <= f1_h3_d;
      f2_sq_q <= f2_sq_d;
      f2_m5_q <= f1_m5_q;
      f2_m2_q <= f1_m2_q;
      f2_x_q  <= f2_x_d;
      f2_mi_q <= f2_mi_d;
      f3_a6_q <= f3_a6_d;
      f3_a3_q <= f3_a3_d;
      f3_m5_q <= f2_m5_q;
      f3_m2_q <= f2_m2_q;
      f3_yp_q <= f3_yp_d;
      f3_x_q  <= f2_x_q;
      f4_q2_q <= f4_q2_d;
      f4_s_q  <= f4_s_d;
      f4_hv_q <= f4_hv_d;
      f5_pr_q <= f5_pr_d;
      f5_n0_q <= f5_n0_d;
      f5_ww_q <= f5_ww_d;
      f5_hv_q <= f4_hv_q;
      f6_dv_q <= f6_dv_d;
      f6_n_q  <= f6_n_d;
      f6_t_q  <= f6_t_d;
      f6_hv_q <= f5_hv_q;
      out_q   <= out_d;
    end
  end

  assign out_valid_o = vld_q[9];
  assign out_data_o  = out_q;

endmodule

// File: sv/esc_div.sv
`timescale 1ns / 1ps

module esc_div import esc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     in_valid_i,
  input  div_in_t  in_data_i,
  output logic     out_valid_o,
  output div_out_t out_data_o
);

  logic [DivW-1:0] vld_q;
  logic [DivW-1:0] rem_q  [DivW];
  logic [DivW-1:0] dq_q   [DivW];
  logic [DivW-1:0] den_q  [DivW];
  div_side_t       side_q [DivW];

  for (genvar i = 0; i < DivW; i++) begin : g_stage
    logic [DivW-1:0] rem_in;
    logic [DivW-1:0] dq_in;
    logic [DivW-1:0] den_in;
    div_side_t       side_in;
    logic [DivW:0]   sh;
    logic [DivW:0]   diff;
    logic            qb;

    if (i == 0) begin : g_head
      assign rem_in  = '0;
      assign dq_in   = in_data_i.num;
      assign den_in  = in_data_i.den;
      assign side_in = in_data_i.side;
    end else begin : g_body
      assign rem_in  = rem_q[i-1];
      assign dq_in   = dq_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign sh   = {rem_in, dq_in[DivW-1]};
    assign diff = sh - {1'b0, den_in};
    assign qb   = ~diff[DivW];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= qb ? diff[DivW-1:0] : sh[DivW-1:0];
        dq_q[i]   <= {dq_in[DivW-2:0], qb};
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivW-2:0], in_valid_i};
    end
  end

  assign out_valid_o     = vld_q[DivW-1];
  assign out_data_o.quo  = dq_q[DivW-1];
  assign out_data_o.side = side_q[DivW-1];

endmodule

// File: sv/esc_back.sv
`timescale 1ns / 1ps

module esc_back import esc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     in_valid_i,
  input  div_out_t in_data_i,
  input  coeff_t   coeff_i,
  output logic     out_valid_o,
  output out_t     out_data_o
);

  logic [4:0]  vld_q;
  div_side_t   side_q [4];

  logic [63:0] g_p_d, g_p_q;
  logic [63:0] h_pp;
  logic [63:0] h_lo_d, h_lo_q, h_p8_d, h_p8_q, h_p_q;
  logic [31:0] h_cr_d, h_cr_q;
  logic [63:0] i_sq_d, i_sq_q, i_p8_q, i_p_q;
  logic [63:0] j_t9_d, j_t9_q, j_p8_q, j_p_q;
  logic [63:0] p7e, k_sum, k_r;
  out_t        out_d, out_q;

  assign g_p_d = in_data_i.side.neg ? 64'd0 - in_data_i.quo : in_data_i.quo;

  assign h_pp   = asr64(g_p_q, 13);
  assign h_lo_d = mul32w(h_pp[31:0], h_pp[31:0]);
  assign h_cr_d = mul32(h_pp[31:0], h_pp[63:32]);
  assign h_p8_d = mul64s16(g_p_q, coeff_i.p8);

  assign i_sq_d = h_lo_q + {h_cr_q[30:0], 33'b0};

  assign j_t9_d = mul64s16(i_sq_q, coeff_i.p9);

  assign p7e   = sx16w64(coeff_i.p7);
  assign k_sum = j_p_q + asr64(j_t9_q, 25) + asr64(j_p8_q, 19);
  assign k_r   = asr64(k_sum, 8) + {p7e[59:0], 4'b0};

  always_comb begin
    out_d.temperature_centi = side_q[3].temp;
    out_d.humidity_q10      = side_q[3].hum;
    out_d.pressure_invalid  = side_q[3].invalid;
    out_d.pressure_pascal   = side_q[3].invalid ? 24'd0 : k_r[31:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= in_data_i.side;
      for (int k = 1; k < 4; k++) begin
        side_q[k] <= side_q[k-1];
      end
      g_p_q  <= g_p_d;
      h_lo_q <= h_lo_d;
      h_cr_q <= h_cr_d;
      h_p8_q <= h_p8_d;
      h_p_q  <= g_p_q;
      i_sq_q <= i_sq_d;
      i_p8_q <= h_p8_q;
      i_p_q  <= h_p_q;
      j_t9_q <= j_t9_d;
      j_p8_q <= i_p8_q;
      j_p_q  <= i_p_q;
      out_q  <= out_d;
    end
  end

  assign out_valid_o = vld_q[4];
  assign out_data_o  = out_q;

endmodule

// File: sv/environmental_sensor_compensation_top.sv
`timescale 1ns / 1ps
// Temperature, pressure and humidity compensation for one raw sample set per beat.
// Input channel: in_valid_i / in_ready_o with the three raw conversions in in_data_i.
// Output channel: out_valid_o / out_ready_i with temperature in 0.01 degC, pressure
// in Pa with an invalid flag for a zero divisor, and humidity in 1/1024 %RH.
// Calibration coefficients are loaded through cfg_we_i / cfg_idx_i / cfg_data_i,
// one register per write; the user must load them only while no beat is in flight,
// which the block does not enforce. A beat reaches the output register through
// 79 register stages: 3 temperature stages, 7 pressure and humidity stages, a
// 64-stage radix-2 restoring divider for the pressure quotient and 5 post-divide
// stages.
// Throughput: one beat per cycle unless the receiver stalls.
// Reset clears all valid bits and zeroes every coefficient register.
// When the receiver stalls, the whole pipeline holds; in_ready_o is high whenever
// the output register is empty or being taken, so no beat is lost or repeated.

module environmental_sensor_compensation_top import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic     en;
  coeff_t   coeff;
  logic     front_vld;
  div_in_t  front_data;
  logic     div_vld;
  div_out_t div_data;

  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  esc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coeff_o    (coeff)
  );

  esc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .coeff_i     (coeff),
    .out_valid_o (front_vld),
    .out_data_o  (front_data)
  );

  esc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (front_vld),
    .in_data_i   (front_data),
    .out_valid_o (div_vld),
    .out_data_o  (div_data)
  );

  esc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (div_vld),
    .in_data_i   (div_data),
    .coeff_i     (coeff),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pressure_invalid |-> out_data_o.pressure_pascal == 24'd0)
    else $error("invalid pressure beat carries nonzero pressure");

  a_hum_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.humidity_q10 <= HumMax)
    else $error("humidity above full scale");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline refuses a beat while the output is empty");

endmodule

// File: dv/environmental_sensor_compensation_top_test.sv
`timescale 1ns / 1ps

module environmental_sensor_compensation_top_test;
  import esc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_data;

  environmental_sensor_compensation_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  logic [47:0] temp_coeffs;
  logic [63:0] press_low;
  logic [63:0] press_mid;
  logic [15:0] press_nine;
  logic [31:0] hum_low;
  logic [39:0] hum_high;

  out_t expected_readings[$];
  int   err_count;
  bit   idle_on;
  int   stall_left;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [31:0] sra32(logic [31:0] x, int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] x, int n);
    logic signed [63:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic out_t compensate(in_t s);
    out_t r;
    logic [31:0] adc_t, adc_h, t1, t2, t3, a, v1, b, v2, fine;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, x, inner, y, w;
    logic [63:0] adc_p, p1, p2, p3, p4, p5, p6, p7, p8, p9, q1, q2, p, n, d, an, ad, q;
    adc_t = {12'd0, s.raw_temperature};
    adc_p = {44'd0, s.raw_pressure};
    adc_h = {16'd0, s.raw_humidity};
    t1 = {16'd0, temp_coeffs[15:0]};
    t2 = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
    t3 = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
    a = (adc_t >> 3) - (t1 << 1);
    v1 = sra32(a * t2, 11);
    b = (adc_t >> 4) - t1;
    v2 = sra32(sra32(b * b, 12) * t3, 14);
    fine = v1 + v2;
    r.temperature_centi = sra32(fine * 32'd5 + 32'd128, 8);

    p1 = {48'd0, press_low[15:0]};
    p2 = {{48{press_low[31]}}, press_low[31:16]};
    p3 = {{48{press_low[47]}}, press_low[47:32]};
    p4 = {{48{press_low[63]}}, press_low[63:48]};
    p5 = {{48{press_mid[15]}}, press_mid[15:0]};
    p6 = {{48{press_mid[31]}}, press_mid[31:16]};
    p7 = {{48{press_mid[47]}}, press_mid[47:32]};
    p8 = {{48{press_mid[63]}}, press_mid[63:48]};
    p9 = {{48{press_nine[15]}}, press_nine};
    q1 = {{32{fine[31]}}, fine} - 64'd128000;
    q2 = q1 * q1 * p6;
    q2 = q2 + ((q1 * p5) << 17);
    q2 = q2 + (p4 << 35);
    q1 = sra64(q1 * q1 * p3, 8) + ((q1 * p2) << 12);
    q1 = sra64(((64'd1 << 47) + q1) * p1, 33);
    r.pressure_invalid = (q1 == 64'd0);
    r.pressure_pascal = '0;
    if (q1 != 64'd0) begin
      p = 64'd1048576 - adc_p;
      n = ((p << 31) - q2) * 64'd3125;
      d = q1;
      an = n[63] ? 64'd0 - n : n;
      ad = d[63] ? 64'd0 - d : d;
      q = an / ad;
      p = (n[63] != d[63]) ? 64'd0 - q : q;
      q1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
      q2 = sra64(p8 * p, 19);
      p = sra64(p + q1 + q2, 8) + (p7 << 4);
      r.pressure_pascal = p[31:8];
    end

    h1 = {24'd0, hum_low[7:0]};
    h2 = {{16{hum_low[23]}}, hum_low[23:8]};
    h3 = {24'd0, hum_low[31:24]};
    h4 = {{16{hum_high[15]}}, hum_high[15:0]};
    h5 = {{16{hum_high[31]}}, hum_high[31:16]};
    h6 = {{24{hum_high[39]}}, hum_high[39:32]};
    v = fine - 32'd76800;
    x = sra32((adc_h << 14) - (h4 << 20) - (h5 * v) + 32'd16384, 15);
    inner = sra32(sra32(v * h6, 10) * (sra32(v * h3, 11) + 32'd32768), 10) + 32'd2097152;
    y = sra32(inner * h2 + 32'd8192, 14);
    v = x * y;
    w = sra32(v, 15);
    v = v - sra32(sra32(w * w, 7) * h1, 4);
    if (v[31]) v = 32'd0;
    else if (v > HumLimit) v = HumLimit;
    r.humidity_q10 = v[28:12];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected beat", {32'd0, out_data.temperature_centi}, 64'd0);
      end else begin
        want = expected_readings.pop_front();
        if (out_data.temperature_centi !== want.temperature_centi)
          report_mismatch("temperature", {32'd0, out_data.temperature_centi},
                          {32'd0, want.temperature_centi});
        if (out_data.pressure_pascal !== want.pressure_pascal)
          report_mismatch("pressure", {40'd0, out_data.pressure_pascal},
                          {40'd0, want.pressure_pascal});
        if (out_data.humidity_q10 !== want.humidity_q10)
          report_mismatch("humidity", {47'd0, out_data.humidity_q10},
                          {47'd0, want.humidity_q10});
        if (out_data.pressure_invalid !== want.pressure_invalid)
          report_mismatch("invalid", {63'd0, out_data.pressure_invalid},
                          {63'd0, want.pressure_invalid});
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_sample(in_t s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(compensate(s));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (expected_readings.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgTemp:      temp_coeffs = value[47:0];
      CfgPressLow:  press_low = value;
      CfgPressMid:  press_mid = value;
      CfgPressNine: press_nine = value[15:0];
      CfgHumLow:    hum_low = value[31:0];
      CfgHumHigh:   hum_high = value[39:0];
      default: ;
    endcase
  endtask

  task automatic load_typical();
    write_reg(CfgTemp, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
    write_reg(CfgPressLow, {16'd2855, 16'd3024, 16'hD643, 16'd36477});
    write_reg(CfgPressMid, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
    write_reg(CfgPressNine, 64'd6000);
    write_reg(CfgHumLow, {32'd0, 8'd0, 16'd362, 8'd75});
    write_reg(CfgHumHigh, {24'd0, 8'd30, 16'd50, 16'd313});
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_8000_8000_8000;
      3: return 64'h7FFF_7FFF_7FFF_7FFF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_random();
    write_reg(CfgTemp, pick_word());
    write_reg(CfgPressLow, pick_word());
    write_reg(CfgPressMid, pick_word());
    write_reg(CfgPressNine, pick_word());
    write_reg(CfgHumLow, pick_word());
    write_reg(CfgHumHigh, pick_word());
  endtask

  function automatic in_t typical_sample();
    in_t s;
    s.raw_temperature = 20'(20'd519888 + $urandom_range(0, 80000) - 20'd40000);
    s.raw_pressure = 20'(20'd415148 + $urandom_range(0, 200000) - 20'd100000);
    s.raw_humidity = 16'($urandom_range(15000, 45000));
    return s;
  endfunction

  function automatic in_t noise_sample();
    in_t s;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    s = bits[55:0];
    return s;
  endfunction

  task automatic test_reset_values();
    send_sample('0);
    send_sample('1);
    send_sample(typical_sample());
    drain();
  endtask

  task automatic test_extremes();
    load_typical();
    send_sample('0);
    send_sample('1);
    send_sample({20'hFFFFF, 20'd0, 16'd0});
    send_sample({20'd0, 20'hFFFFF, 16'hFFFF});
    send_sample({20'h80000, 20'h80000, 16'h8000});
    send_sample({20'h7FFFF, 20'h7FFFF, 16'h7FFF});
    for (int i = 0; i < 6; i++) send_sample(typical_sample());
    drain();
    write_reg(CfgPressLow, {16'd2855, 16'd3024, 16'hD643, 16'd0});
    write_reg(cfg_idx_e'(3'd6), '1);
    send_sample(typical_sample());
    send_sample('1);
    drain();
    write_reg(CfgHumHigh, {24'd0, 8'h7F, 16'h8000, 16'h8000});
    send_sample({20'd519888, 20'd415148, 16'hFFFF});
    drain();
    write_reg(CfgHumHigh, {24'd0, 8'h80, 16'h7FFF, 16'h7FFF});
    send_sample({20'd519888, 20'd415148, 16'd0});
    drain();
  endtask

  task automatic test_random_sets();
    for (int set = 0; set < 12; set++) begin
      if (set % 3 == 0) load_typical();
      else load_random();
      for (int i = 0; i < 50; i++)
        send_sample($urandom_range(0, 3) == 0 ? noise_sample() : typical_sample());
      drain();
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    load_typical();
    for (int i = 0; i < 80; i++)
      send_sample($urandom_range(0, 3) == 0 ? noise_sample() : typical_sample());
    drain();
  endtask

  initial begin
    #4_000_000;
    $display("environmental_sensor_compensation_top regression: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    stall_left = 0;
    err_count = 0;
    idle_on = 1'b1;
    temp_coeffs = '0;
    press_low = '0;
    press_mid = '0;
    press_nine = '0;
    hum_low = '0;
    hum_high = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_random_sets();
    test_full_rate();
    if (err_count == 0) begin
      $display("environmental_sensor_compensation_top regression: pass");
    end else begin
      $display("environmental_sensor_compensation_top regression: fail");
    end
    $finish;
  end

endmodule
